@@ rtl/sorted_set_insert_defines.svh @@
// Assertion macros shared by the sorted set RTL.
// Depends on nothing; included by the controller and the datapath.
`ifndef SORTED_SET_INSERT_DEFINES_SVH
`define SORTED_SET_INSERT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SSI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SSI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SSI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/ssi_pkg.sv @@
// Package for the sorted set block: sizes, field types, codes and the
// command and status structs between controller and datapath. No dependencies.
package ssi_pkg;

	// Store size and derived widths.
	localparam int CAPACITY = 64;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Fixed field widths.
	localparam int KIND_W = 2;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 6;
	localparam int STATUS_W = 3;
	localparam int POS_W = 7;
	localparam int SIZE_W = 7;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Item kinds.
	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_READ = 2'd1;
	localparam kind_t KIND_CLEAR = 2'd2;

	// Result status codes.
	localparam status_t ST_INSERTED = 3'd0;
	localparam status_t ST_DUPLICATE = 3'd1;
	localparam status_t ST_FULL = 3'd2;
	localparam status_t ST_READ_OK = 3'd3;
	localparam status_t ST_EMPTY = 3'd4;

	// Walk pointer operations.
	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_COUNT,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	// Memory read address sources.
	typedef enum logic [1:0] {
		RD_PTR,
		RD_PTR_M1,
		RD_INDEX
	} rd_sel_t;

	// Result position sources.
	typedef enum logic [1:0] {
		POS_PTR,
		POS_SAVED,
		POS_INDEX,
		POS_ZERO
	} pos_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic in_take;
		ptr_op_t ptr_op;
		logic rd_en;
		rd_sel_t rd_sel;
		logic wr_en;
		logic wr_val;
		logic pos_load;
		logic cnt_inc;
		logic cnt_clr;
		logic res_set;
		status_t res_status;
		pos_sel_t res_pos;
		logic res_use_rd;
		logic out_load;
	} ssi_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		kind_t in_kind;
		logic ptr_eq_count;
		logic ptr_eq_pos;
		logic full;
		logic idx_lt_count;
		logic rd_lt_val;
		logic rd_eq_val;
		logic out_free;
	} ssi_sts_t;

endpackage

@@ rtl/ssi_if.sv @@
// Handshake interfaces for the request and response channels of the sorted set.
// Depends on ssi_pkg for the field widths.
interface ssi_req_if;
	logic valid;
	logic ready;
	logic [ssi_pkg::KIND_W-1:0] kind;
	logic signed [ssi_pkg::VALUE_W-1:0] value;
	logic [ssi_pkg::INDEX_W-1:0] index;

	modport source(output valid, kind, value, index, input ready);
	modport sink(input valid, kind, value, index, output ready);
endinterface

interface ssi_rsp_if;
	logic valid;
	logic ready;
	logic [ssi_pkg::STATUS_W-1:0] status;
	logic [ssi_pkg::POS_W-1:0] position;
	logic signed [ssi_pkg::VALUE_W-1:0] entry_value;
	logic [ssi_pkg::SIZE_W-1:0] set_size;

	modport source(output valid, status, position, entry_value, set_size, input ready);
	modport sink(input valid, status, position, entry_value, set_size, output ready);
endinterface

@@ rtl/ssi_ctrl.sv @@
// Controller state machine of the sorted set: sequences search, shift, read
// and result hand-off. Depends on ssi_pkg and the assertion macro header.
`include "sorted_set_insert_defines.svh"

module ssi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  ssi_pkg::ssi_sts_t sts,
	output ssi_pkg::ssi_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SRCH_RD  = 8'b0000_0010,
		S_SRCH_CMP = 8'b0000_0100,
		S_SHIFT_RD = 8'b0000_1000,
		S_SHIFT_WR = 8'b0001_0000,
		S_READ     = 8'b0010_0000,
		S_RD_WAIT  = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.ptr_op = ssi_pkg::PTR_HOLD;
		cmd.rd_sel = ssi_pkg::RD_PTR;
		cmd.res_pos = ssi_pkg::POS_ZERO;
		cmd.res_status = ssi_pkg::ST_EMPTY;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.in_take = 1'b1;
					if (sts.in_kind == ssi_pkg::KIND_INSERT) begin
						cmd.ptr_op = ssi_pkg::PTR_ZERO;
						state_d = S_SRCH_RD;
					end else if (sts.in_kind == ssi_pkg::KIND_READ) begin
						state_d = S_READ;
					end else begin
						// Clear empties the set; the unused kind only reports.
						cmd.cnt_clr = (sts.in_kind == ssi_pkg::KIND_CLEAR);
						cmd.res_set = 1'b1;
						cmd.res_status = ssi_pkg::ST_EMPTY;
						cmd.res_pos = ssi_pkg::POS_ZERO;
						state_d = S_DONE;
					end
				end
			end
			S_SRCH_RD: begin
				if (sts.ptr_eq_count) begin
					// Every stored entry is smaller: the value goes on top.
					if (sts.full) begin
						cmd.res_set = 1'b1;
						cmd.res_status = ssi_pkg::ST_FULL;
						cmd.res_pos = ssi_pkg::POS_ZERO;
						state_d = S_DONE;
					end else begin
						cmd.pos_load = 1'b1;
						state_d = S_SHIFT_RD;
					end
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = ssi_pkg::RD_PTR;
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (sts.rd_lt_val) begin
					cmd.ptr_op = ssi_pkg::PTR_INC;
					state_d = S_SRCH_RD;
				end else if (sts.rd_eq_val) begin
					cmd.res_set = 1'b1;
					cmd.res_status = ssi_pkg::ST_DUPLICATE;
					cmd.res_pos = ssi_pkg::POS_PTR;
					state_d = S_DONE;
				end else if (sts.full) begin
					cmd.res_set = 1'b1;
					cmd.res_status = ssi_pkg::ST_FULL;
					cmd.res_pos = ssi_pkg::POS_ZERO;
					state_d = S_DONE;
				end else begin
					// Insert point found; shift from the top down to it.
					cmd.pos_load = 1'b1;
					cmd.ptr_op = ssi_pkg::PTR_COUNT;
					state_d = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (sts.ptr_eq_pos) begin
					cmd.wr_en = 1'b1;
					cmd.wr_val = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.res_set = 1'b1;
					cmd.res_status = ssi_pkg::ST_INSERTED;
					cmd.res_pos = ssi_pkg::POS_SAVED;
					state_d = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = ssi_pkg::RD_PTR_M1;
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_en = 1'b1;
				cmd.ptr_op = ssi_pkg::PTR_DEC;
				state_d = S_SHIFT_RD;
			end
			S_READ: begin
				if (sts.idx_lt_count) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = ssi_pkg::RD_INDEX;
					state_d = S_RD_WAIT;
				end else begin
					cmd.res_set = 1'b1;
					cmd.res_status = ssi_pkg::ST_EMPTY;
					cmd.res_pos = ssi_pkg::POS_INDEX;
					state_d = S_DONE;
				end
			end
			S_RD_WAIT: begin
				cmd.res_set = 1'b1;
				cmd.res_status = ssi_pkg::ST_READ_OK;
				cmd.res_pos = ssi_pkg::POS_INDEX;
				cmd.res_use_rd = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				// Hand the result to the output register once it is free.
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SSI_ASSERT_NXT(a_take_leaves_idle, clk, arst_n, cmd.in_take, state_q != S_IDLE, "accepted transaction did not start work")
	`SSI_ASSERT_NXT(a_done_releases, clk, arst_n, (state_q == S_DONE) && sts.out_free, state_q == S_IDLE, "finished item did not return to idle")

endmodule

@@ rtl/ssi_datapath.sv @@
// Datapath of the sorted set: entry memory, walk pointer, count, result
// staging and output register. Depends on ssi_pkg, the interfaces and macros.
`include "sorted_set_insert_defines.svh"

module ssi_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ssi_pkg::ssi_cmd_t cmd,
	output ssi_pkg::ssi_sts_t sts,
	ssi_req_if.sink           req,
	ssi_rsp_if.source         rsp
);

	localparam int CMP_W = (ssi_pkg::CNT_W > ssi_pkg::INDEX_W) ?
		ssi_pkg::CNT_W : ssi_pkg::INDEX_W;

	logic signed [ssi_pkg::VALUE_W-1:0] sorted_q [ssi_pkg::CAPACITY];
	logic signed [ssi_pkg::VALUE_W-1:0] rd_data_q;
	logic signed [ssi_pkg::VALUE_W-1:0] val_q;
	logic [ssi_pkg::INDEX_W-1:0] idx_q;
	logic [ssi_pkg::CNT_W-1:0] ptr_q;
	logic [ssi_pkg::CNT_W-1:0] ptr_m1;
	logic [ssi_pkg::CNT_W-1:0] pos_q;
	logic [ssi_pkg::CNT_W-1:0] count_q;
	logic [ssi_pkg::IDX_W-1:0] rd_addr;
	logic [ssi_pkg::IDX_W-1:0] wr_addr;
	ssi_pkg::status_t res_status_q;
	logic [ssi_pkg::POS_W-1:0] res_pos_q;
	logic [ssi_pkg::POS_W-1:0] res_pos_d;
	logic signed [ssi_pkg::VALUE_W-1:0] res_value_q;
	logic out_valid_q;
	ssi_pkg::status_t out_status_q;
	logic [ssi_pkg::POS_W-1:0] out_pos_q;
	logic signed [ssi_pkg::VALUE_W-1:0] out_value_q;
	logic [ssi_pkg::SIZE_W-1:0] out_size_q;

	// Input latch for the accepted transaction.
	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			val_q <= req.value;
			idx_q <= req.index;
		end
	end

	// Walk pointer and saved insert position.
	assign ptr_m1 = ptr_q - ssi_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			case (cmd.ptr_op)
				ssi_pkg::PTR_ZERO: ptr_q <= '0;
				ssi_pkg::PTR_COUNT: ptr_q <= count_q;
				ssi_pkg::PTR_INC: ptr_q <= ptr_q + ssi_pkg::CNT_W'(1);
				ssi_pkg::PTR_DEC: ptr_q <= ptr_m1;
				default: ptr_q <= ptr_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_load) begin
			pos_q <= ptr_q;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_clr) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + ssi_pkg::CNT_W'(1);
		end
	end

	// Entry memory: one write and one registered read per cycle.
	always_comb begin
		case (cmd.rd_sel)
			ssi_pkg::RD_PTR_M1: rd_addr = ptr_m1[ssi_pkg::IDX_W-1:0];
			ssi_pkg::RD_INDEX: rd_addr = ssi_pkg::IDX_W'(idx_q);
			default: rd_addr = ptr_q[ssi_pkg::IDX_W-1:0];
		endcase
	end

	assign wr_addr = ptr_q[ssi_pkg::IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			sorted_q[wr_addr] <= cmd.wr_val ? val_q : rd_data_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= sorted_q[rd_addr];
		end
	end

	// Result staging.
	always_comb begin
		case (cmd.res_pos)
			ssi_pkg::POS_PTR: res_pos_d = ssi_pkg::POS_W'(ptr_q);
			ssi_pkg::POS_SAVED: res_pos_d = ssi_pkg::POS_W'(pos_q);
			ssi_pkg::POS_INDEX: res_pos_d = ssi_pkg::POS_W'(idx_q);
			default: res_pos_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_pos_q <= res_pos_d;
			res_value_q <= cmd.res_use_rd ? rd_data_q : '0;
		end
	end

	// Output register; the size is taken after the item has updated the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_pos_q <= res_pos_q;
			out_value_q <= res_value_q;
			out_size_q <= ssi_pkg::SIZE_W'(count_q);
		end
	end

	assign req.ready = cmd.in_ready;
	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.position = out_pos_q;
	assign rsp.entry_value = out_value_q;
	assign rsp.set_size = out_size_q;

	// Status back to the controller.
	always_comb begin
		sts.in_valid = req.valid;
		sts.in_kind = req.kind;
		sts.ptr_eq_count = (ptr_q == count_q);
		sts.ptr_eq_pos = (ptr_q == pos_q);
		sts.full = (count_q == ssi_pkg::CNT_W'(ssi_pkg::CAPACITY));
		sts.idx_lt_count = (CMP_W'(idx_q) < CMP_W'(count_q));
		sts.rd_lt_val = (rd_data_q < val_q);
		sts.rd_eq_val = (rd_data_q == val_q);
		sts.out_free = !out_valid_q || rsp.ready;
	end

	`SSI_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= ssi_pkg::CNT_W'(ssi_pkg::CAPACITY), "entry count above capacity")
	`SSI_ASSERT_NXT(a_count_step, clk, arst_n, cmd.cnt_inc, count_q == ssi_pkg::CNT_W'($past(count_q) + 1'b1), "insert did not grow the count by one")
	`SSI_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || rsp.ready, "pending result overwritten")

endmodule

@@ rtl/sorted_set_insert.sv @@
// Sorted set of distinct signed 32-bit values in a store of CAPACITY entries.
// Request channel req carries kind, value and index; response channel rsp
// carries status, position, entry_value and set_size, one response per request.
// A request is taken while the block is idle; one item is worked at a time.
// The single read port of the entry memory sets the pace of an insert: the
// search reads one smaller entry at a time, then the shift moves one larger
// entry at a time.
// A duplicate or a full store is reported once the search reaches the value's
// sorted position.
// The response sits in an output register, so the next request is accepted
// while the previous response waits; a stalled receiver holds the block in its
// final step only when a second response is ready to replace the first.
// Reset empties the set at once; the entry memory is not cleared, because
// entries at or above the count are never read.
// Depends on ssi_pkg, the interfaces, ssi_ctrl and ssi_datapath.
module sorted_set_insert (
	input  logic      clk,
	input  logic      arst_n,
	ssi_req_if.sink   req,
	ssi_rsp_if.source rsp
);

	ssi_pkg::ssi_cmd_t cmd;
	ssi_pkg::ssi_sts_t sts;

	// Sequencer.
	ssi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Storage and result path.
	ssi_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
